@@ src/psa_pkg.sv @@
// ----------------------------------------------------------------------------
// psa_pkg
// Types and constants shared by the slot allocator modules.
// ----------------------------------------------------------------------------
package psa_pkg;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_TICK  = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	localparam int CFG_W     = 7;
	localparam int PRIO_W    = 8;
	localparam int LIFE_W    = 15;
	localparam int IDX_W     = 6;
	localparam int EXPIRED_W = 7;

	localparam logic [CFG_W-1:0]  ACTIVE_RESET = 7'd64;
	localparam logic [PRIO_W-1:0] PRIO_FREE    = 8'd128;

	// One table slot. A set free bit together with all ones in life is the
	// lifetime value -1.
	typedef struct packed {
		logic              free;
		logic [LIFE_W-1:0] life;
		logic [PRIO_W-1:0] prio;
		logic              prot;
	} psa_entry_t;

	localparam psa_entry_t FREE_ENTRY = '{
		free: 1'b1,
		life: {LIFE_W{1'b1}},
		prio: PRIO_FREE,
		prot: 1'b0
	};

	typedef struct packed {
		logic [1:0]        req_type;
		logic [IDX_W-1:0]  entry_index;
		logic [LIFE_W-1:0] life;
		logic              protect;
		logic [PRIO_W-1:0] priority_req;
	} psa_req_t;

	// Declared from the highest bit down, so granted sits in bit 0.
	typedef struct packed {
		logic [EXPIRED_W-1:0] expired_count;
		logic                 replaced_live;
		logic [IDX_W-1:0]     slot_index;
		logic                 granted;
	} psa_result_t;

endpackage

@@ src/psa_table.sv @@
// ----------------------------------------------------------------------------
// psa_table
// Slot table memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module psa_table #(
	parameter int MAX_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
	output psa_pkg::psa_entry_t          rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_SLOTS)-1:0] wr_addr,
	input  psa_pkg::psa_entry_t          wr_data
);

	psa_pkg::psa_entry_t mem [MAX_SLOTS];
	psa_pkg::psa_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ src/psa_engine.sv @@
// ----------------------------------------------------------------------------
// psa_engine
// Request sequencer: walks the slot table through the memory port, one read
// issued per cycle, and writes modified entries back.
// ----------------------------------------------------------------------------
module psa_engine #(
	parameter int MAX_SLOTS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [psa_pkg::CFG_W-1:0]    active_entries,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  psa_pkg::psa_req_t            in_req,
	output logic                         res_valid,
	input  logic                         res_ready,
	output psa_pkg::psa_result_t         res,
	output logic                         rd_en,
	output logic [$clog2(MAX_SLOTS)-1:0] rd_addr,
	input  psa_pkg::psa_entry_t          rd_data,
	output logic                         wr_en,
	output logic [$clog2(MAX_SLOTS)-1:0] wr_addr,
	output psa_pkg::psa_entry_t          wr_data
);

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int CW = $clog2(MAX_SLOTS + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN1 = 3'd2;
	localparam logic [2:0] ST_SCAN2 = 3'd3;
	localparam logic [2:0] ST_TICK  = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	logic [2:0]                      state_q;
	logic [IW-1:0]                   ptr_q;
	logic [CW-1:0]                   cnt_q;
	logic [CW-1:0]                   start_q;
	logic [psa_pkg::PRIO_W-1:0]      prio_q;
	logic                            prot_q;
	logic [psa_pkg::LIFE_W-1:0]      life_q;
	logic [psa_pkg::EXPIRED_W-1:0]   expired_q;
	psa_pkg::psa_result_t            res_q;
	logic                            vld_s1;
	logic                            last_s1;
	logic [IW-1:0]                   addr_s1;

	logic [CW-1:0]                   size;
	logic [CW-1:0]                   ptr_inc;
	logic [IW-1:0]                   ptr_nxt;
	logic [CW-1:0]                   alloc_start;
	logic                            scan;
	logic                            hit;
	logic                            stop;
	logic                            issue;
	logic                            idx_ok;
	logic                            expire;
	logic [psa_pkg::EXPIRED_W-1:0]   expired_nxt;
	psa_pkg::psa_entry_t             new_entry;
	psa_pkg::psa_entry_t             aged_entry;

	// A register value of zero acts as one slot, and the size never exceeds
	// the table.
	always_comb begin
		if (active_entries == '0) begin
			size = CW'(1);
		end else if (32'(active_entries) > MAX_SLOTS) begin
			size = CW'(MAX_SLOTS);
		end else begin
			size = CW'(active_entries);
		end
	end

	assign ptr_inc     = CW'(ptr_q) + CW'(1);
	assign ptr_nxt     = (ptr_inc >= size) ? '0 : ptr_inc[IW-1:0];
	assign alloc_start = (start_q >= size) ? '0 : start_q;
	assign idx_ok      = 32'(in_req.entry_index) < 32'(size);

	assign scan = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);

	// The first pass looks for a free slot, the second for an evictable one.
	always_comb begin
		if (state_q == ST_SCAN1) begin
			hit = rd_data.free;
		end else begin
			hit = (prio_q <= rd_data.prio) &&
				((prio_q != rd_data.prio) || !rd_data.prot);
		end
	end

	assign stop  = vld_s1 && (last_s1 || (scan && hit));
	assign issue = (scan || (state_q == ST_TICK)) && (cnt_q < size) && !stop;

	assign rd_en   = issue;
	assign rd_addr = ptr_q;

	assign expire      = !rd_data.free && (rd_data.life == '0);
	assign expired_nxt = expired_q + psa_pkg::EXPIRED_W'(expire);

	always_comb begin
		new_entry      = '0;
		new_entry.free = 1'b0;
		new_entry.life = life_q;
		new_entry.prio = prio_q;
		new_entry.prot = prot_q;
		aged_entry      = rd_data;
		aged_entry.life = rd_data.life - psa_pkg::LIFE_W'(1);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = psa_pkg::FREE_ENTRY;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q;
			end
			ST_IDLE: begin
				if (in_valid && (in_req.req_type == psa_pkg::REQ_FREE) && idx_ok) begin
					wr_en   = 1'b1;
					wr_addr = IW'(in_req.entry_index);
				end
			end
			ST_SCAN1, ST_SCAN2: begin
				if (vld_s1 && hit) begin
					wr_en   = 1'b1;
					wr_data = new_entry;
				end
			end
			ST_TICK: begin
				if (vld_s1 && !rd_data.free) begin
					wr_en   = 1'b1;
					wr_data = expire ? psa_pkg::FREE_ENTRY : aged_entry;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RESP);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ptr_q   <= '0;
			cnt_q   <= '0;
			start_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				ptr_q <= ptr_nxt;
				cnt_q <= cnt_q + CW'(1);
			end
			unique case (state_q)
				ST_CLEAR: begin
					ptr_q <= ptr_q + IW'(1);
					if (ptr_q == IW'(MAX_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						unique case (in_req.req_type)
							psa_pkg::REQ_ALLOC: begin
								start_q <= alloc_start;
								ptr_q   <= alloc_start[IW-1:0];
								state_q <= ST_SCAN1;
							end
							psa_pkg::REQ_TICK: begin
								ptr_q   <= '0;
								state_q <= ST_TICK;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN1, ST_SCAN2: begin
					// A hit or the last slot stops the read issue, so the read
					// pipeline is already empty here.
					if (vld_s1 && hit) begin
						start_q <= CW'(addr_s1) + CW'(1);
						state_q <= ST_RESP;
					end else if (vld_s1 && last_s1) begin
						if (state_q == ST_SCAN1) begin
							ptr_q   <= start_q[IW-1:0];
							cnt_q   <= '0;
							state_q <= ST_SCAN2;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_TICK: begin
					if (vld_s1 && last_s1) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request fields, the read pipeline tags and the result need no reset.
	always_ff @(posedge clk) begin
		if (issue) begin
			addr_s1 <= ptr_q;
			last_s1 <= (cnt_q == size - CW'(1));
		end
		unique case (state_q)
			ST_IDLE: begin
				prio_q    <= in_req.priority_req;
				prot_q    <= in_req.protect;
				life_q    <= in_req.life;
				expired_q <= '0;
				if (in_req.req_type == psa_pkg::REQ_FREE && idx_ok) begin
					res_q <= {{psa_pkg::EXPIRED_W{1'b0}}, 1'b0, in_req.entry_index, 1'b1};
				end else begin
					res_q <= '0;
				end
			end
			ST_SCAN1, ST_SCAN2: begin
				if (vld_s1 && hit) begin
					res_q <= {{psa_pkg::EXPIRED_W{1'b0}}, !rd_data.free,
						psa_pkg::IDX_W'(addr_s1), 1'b1};
				end
			end
			ST_TICK: begin
				if (vld_s1) begin
					expired_q <= expired_nxt;
					if (last_s1) begin
						res_q <= {expired_nxt, 1'b0, {psa_pkg::IDX_W{1'b0}}, 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ src/priority_slot_allocator.sv @@
// ----------------------------------------------------------------------------
// priority_slot_allocator
// Slot table with lifetimes, rotating allocation and priority eviction.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ stream: tuser carries the request type (allocate,
// tick or free), tdata the priority, protect mark, lifetime and slot number.
// Each request gives exactly one result transfer on the m_ stream. The user
// must write the size register over the cfg channel only while the block is
// idle; the block does not enforce it. One request is worked at a time; the
// memory read port sets the pace at one slot per cycle. With N slots in use,
// an allocate reads up to N slots when a free slot is found in the first pass
// and up to 2N when the eviction pass runs; a tick reads N and a free none.
// After reset the table memory is cleared in a pass over all MAX_SLOTS slots,
// during which s_tready stays low; configuration writes are still taken.
// Results go through an output register, so the next request is accepted
// while a result waits. If the receiver stalls with a result still held,
// the following result waits in the sequencer and s_tready stays low.
// ----------------------------------------------------------------------------
module priority_slot_allocator #(
	parameter int MAX_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,   // active_entries
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // priority_req, protect, life, entry_index, pad
	input  logic [1:0]  s_tuser,    // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata     // granted, slot_index, replaced_live, expired_count, pad
);

	localparam int IW = $clog2(MAX_SLOTS);

	logic [psa_pkg::CFG_W-1:0] active_q;
	psa_pkg::psa_req_t         req;
	psa_pkg::psa_result_t      res;
	psa_pkg::psa_result_t      out_q;
	logic                      m_tvalid_q;
	logic                      res_valid;
	logic                      res_ready;
	logic                      rd_en;
	logic [IW-1:0]             rd_addr;
	psa_pkg::psa_entry_t       rd_data;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	psa_pkg::psa_entry_t       wr_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= psa_pkg::ACTIVE_RESET;
		end else if (cfg_valid) begin
			active_q <= cfg_data;
		end
	end

	assign req.req_type     = s_tuser;
	assign req.priority_req = s_tdata[7:0];
	assign req.protect      = s_tdata[8];
	assign req.life         = s_tdata[23:9];
	assign req.entry_index  = s_tdata[29:24];

	psa_engine #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.active_entries(active_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_req        (req),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.rd_en         (rd_en),
		.rd_addr       (rd_addr),
		.rd_data       (rd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data)
	);

	psa_table #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_table (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_q};

endmodule
